### hw/rtl/rlim_pkg.sv
// Package for the per-user sliding-window rate limiter.
// Shared widths, reset values, register codes and controller/datapath structs.
// No dependencies.
package rlim_pkg;

  localparam int USERS_DEF      = 64;
  localparam int HIST_DEPTH_DEF = 16;

  localparam int USER_W     = 6;
  localparam int NOW_W      = 32;
  localparam int MAXM_W     = 4;
  localparam int WINDOW_W   = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  localparam logic [MAXM_W-1:0]   MSG_LIMIT_RESET = 4'd10;
  localparam logic [WINDOW_W-1:0] WINDOW_MS_RESET = 32'd6000;

  localparam logic [CFG_IDX_W-1:0] CFG_MSG_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS = 1'd1;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic load_meta;
    logic expire;
    logic commit;
    logic respond;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic skip;
    logic can_expire;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/per_user_sliding_window_rate_limiter.sv
// Top level of the per-user sliding-window rate limiter.
// Depends on rlim_pkg, rlim_ctrl, rlim_dp (and rlim_ram through rlim_dp).
//
//   port group   dir  contents
//   s_axis_*     in   tdata: user_index[5:0], now_ms[37:6]; tuser: exempt
//   m_axis_*     out  tdata: spamming[0]
//   cfg_*        in   index 0 message limit, index 1 window_ms
//
// A message is accepted, its ring state is read and loaded, then expired stamps
// are dropped by the one-read-per-cycle walk of the stamp RAM before the commit.
// An exempt or out-of-range message skips the load and walk and only responds.
// After reset a clearing pass zeroes the ring state of every user; no input
// word is taken during it. A result waiting on m_axis_tready holds, and the next
// word is still accepted; its result waits until the output register frees.
module per_user_sliding_window_rate_limiter #(
  parameter int USERS         = rlim_pkg::USERS_DEF,
  parameter int HISTORY_DEPTH = rlim_pkg::HIST_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [rlim_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // user_index, now_ms, pad
  input  logic                             s_axis_tuser,  // exempt
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [rlim_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // spamming, pad
  input  logic                             cfg_we_i,
  input  logic [rlim_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rlim_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  rlim_pkg::cmd_t cmd;
  rlim_pkg::sts_t sts;
  logic           spamming;

  rlim_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rlim_dp #(
    .USERS         (USERS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .user_i      (s_axis_tdata[rlim_pkg::USER_W-1:0]),
    .now_i       (s_axis_tdata[rlim_pkg::USER_W+rlim_pkg::NOW_W-1:rlim_pkg::USER_W]),
    .exempt_i    (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .spamming_o  (spamming),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  assign m_axis_tdata = {{(rlim_pkg::OUT_TDATA_W-1){1'b0}}, spamming};

endmodule

### hw/rtl/rlim_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rlim_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/rlim_ctrl.sv
// Controller for the rate limiter: sequences clear, lookup, expiry and commit.
// Depends on rlim_pkg.
module rlim_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rlim_pkg::sts_t sts_i,
  output rlim_pkg::cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_META   = 6'b000100,
    ST_EXPIRE = 6'b001000,
    ST_COMMIT = 6'b010000,
    ST_RESP   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_META;
        end
      end
      ST_META: begin
        if (sts_i.skip) begin
          state_d = ST_RESP;
        end else begin
          cmd_o.load_meta = 1'b1;
          state_d         = ST_EXPIRE;
        end
      end
      ST_EXPIRE: begin
        if (sts_i.can_expire) begin
          cmd_o.expire = 1'b1;
        end else begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.respond = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

### hw/rtl/rlim_dp.sv
// Datapath for the rate limiter: config registers, stamp and ring-state RAMs,
// expiry compare, ring update and result register. Depends on rlim_pkg, rlim_ram.
module rlim_dp #(
  parameter int USERS         = rlim_pkg::USERS_DEF,
  parameter int HISTORY_DEPTH = rlim_pkg::HIST_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rlim_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rlim_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [rlim_pkg::USER_W-1:0]     user_i,
  input  logic [rlim_pkg::NOW_W-1:0]      now_i,
  input  logic                            exempt_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic                            spamming_o,
  input  rlim_pkg::cmd_t                  cmd_i,
  output rlim_pkg::sts_t                  sts_o
);

  localparam int UA_W        = (USERS > 1) ? $clog2(USERS) : 1;
  localparam int HEAD_W      = $clog2(HISTORY_DEPTH);
  localparam int CNT_W       = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;
  localparam int META_W      = HEAD_W + CNT_W;
  localparam int STAMP_DEPTH = USERS * (2 ** HEAD_W);

  logic [rlim_pkg::MAXM_W-1:0]   max_q, max_d;
  logic [rlim_pkg::WINDOW_W-1:0] window_q, window_d;

  logic [rlim_pkg::USER_W-1:0] user_q;
  logic [rlim_pkg::NOW_W-1:0]  now_q;
  logic                        skip_q;
  logic [HEAD_W-1:0]           head_q, head_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic [UA_W-1:0]             clr_q;
  logic                        out_valid_q, spam_q;

  logic [UA_W-1:0]    user_a;
  logic [META_W-1:0]  meta_rdata, meta_wdata;
  logic [UA_W-1:0]    meta_waddr;
  logic               meta_we;
  logic [HEAD_W-1:0]  meta_head;
  logic [CNT_W-1:0]   meta_count;
  logic [31:0]        stamp_rdata;
  logic [HEAD_W-1:0]  rd_head, head_inc, head2, idx;
  logic [CNT_W-1:0]   count2, count3;
  logic [SUM_W-1:0]   sum, sum_wrap;
  logic [31:0]        age;
  logic               full, spam;

  // config registers
  always_comb begin
    max_d    = max_q;
    window_d = window_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        rlim_pkg::CFG_MSG_LIMIT: max_d    = cfg_data_i[rlim_pkg::MAXM_W-1:0];
        rlim_pkg::CFG_WINDOW_MS: window_d = cfg_data_i[rlim_pkg::WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= rlim_pkg::MSG_LIMIT_RESET;
      window_q <= rlim_pkg::WINDOW_MS_RESET;
    end else begin
      max_q    <= max_d;
      window_q <= window_d;
    end
  end

  // item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      user_q <= user_i;
      now_q  <= now_i;
      skip_q <= exempt_i || (32'(user_i) >= 32'(USERS));
    end
  end

  assign user_a = UA_W'(user_q);

  // ring-state RAM: {head, count} per user
  assign meta_head  = meta_rdata[META_W-1:CNT_W];
  assign meta_count = meta_rdata[CNT_W-1:0];

  rlim_ram #(
    .WIDTH (META_W),
    .DEPTH (USERS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (UA_W'(user_i)),
    .rdata_o (meta_rdata)
  );

  // expiry walk
  assign head_inc = (head_q == HEAD_W'(HISTORY_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign rd_head  = cmd_i.load_meta ? meta_head : (cmd_i.expire ? head_inc : head_q);
  assign age      = now_q - stamp_rdata;

  rlim_ram #(
    .WIDTH (32),
    .DEPTH (STAMP_DEPTH)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i ({user_a, idx}),
    .wdata_i (now_q),
    .raddr_i ({user_a, rd_head}),
    .rdata_o (stamp_rdata)
  );

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (cmd_i.load_meta) begin
      head_d  = meta_head;
      count_d = meta_count;
    end else if (cmd_i.expire) begin
      head_d  = head_inc;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q  <= head_d;
    count_q <= count_d;
  end

  // append and limit check
  assign full     = (count_q == CNT_W'(HISTORY_DEPTH));
  assign head2    = full ? head_inc : head_q;
  assign count2   = full ? CNT_W'(HISTORY_DEPTH - 1) : count_q;
  assign sum      = SUM_W'(head2) + SUM_W'(count2);
  assign sum_wrap = (sum >= SUM_W'(HISTORY_DEPTH)) ? sum - SUM_W'(HISTORY_DEPTH) : sum;
  assign idx      = sum_wrap[HEAD_W-1:0];
  assign count3   = count2 + 1'b1;
  assign spam     = (32'(count3) > 32'(max_q));

  assign meta_we    = cmd_i.clr_step || cmd_i.commit;
  assign meta_waddr = cmd_i.clr_step ? clr_q : user_a;
  assign meta_wdata = (cmd_i.clr_step || spam) ? '0 : {head2, count3};

  // clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit || cmd_i.respond) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      spam_q <= spam;
    end else if (cmd_i.respond) begin
      spam_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign spamming_o  = spam_q;

  assign sts_o.clr_last   = (clr_q == UA_W'(USERS - 1));
  assign sts_o.skip       = skip_q;
  assign sts_o.can_expire = (count_q != '0) && (age > window_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

### tb/tb_per_user_sliding_window_rate_limiter.sv
`timescale 1ns / 100ps
// Self-checking testbench for per_user_sliding_window_rate_limiter.
// Predicts the spamming flag per message from a per-user stamp ring model.
// Depends on rlim_pkg and the limiter RTL.
module tb_per_user_sliding_window_rate_limiter;

  localparam int N_USERS        = 64;
  localparam int RING_DEPTH     = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 40;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [rlim_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // user_index[5:0], now_ms[37:6], pad
  logic                             s_axis_tuser;   // exempt
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [rlim_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // spamming[0], pad
  logic                             cfg_we_i;
  logic [rlim_pkg::CFG_IDX_W-1:0]   cfg_index_i;
  logic [rlim_pkg::CFG_DATA_W-1:0]  cfg_data_i;

  per_user_sliding_window_rate_limiter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // limiter state as the block should hold it
  logic [31:0]                 stamp_ring [N_USERS][RING_DEPTH];
  logic [3:0]                  oldest_pos [N_USERS];
  logic [4:0]                  stamp_cnt  [N_USERS];
  logic [rlim_pkg::MAXM_W-1:0] msg_limit;
  logic [31:0]                 window_len;

  logic        spam_expect_q[$];
  logic        spam_exp;
  int          mismatch_count;
  int          idle_cycles;
  int          sender_gap_max;
  int          recv_gap_max;
  int          rx_wait;
  int          hold_left;
  int          hold_request;
  logic [31:0] clock_ms;

  function automatic logic rate_predict(input logic [5:0] user, input logic [31:0] now,
                                        input logic exempt);
    logic [3:0]  hd;
    logic [4:0]  cnt;
    logic [31:0] age;
    if (exempt) return 1'b0;
    hd  = oldest_pos[user];
    cnt = stamp_cnt[user];
    age = now - stamp_ring[user][hd];
    while (cnt > 0 && age > window_len) begin
      hd  = hd + 4'd1;
      cnt = cnt - 5'd1;
      age = now - stamp_ring[user][hd];
    end
    if (cnt >= RING_DEPTH) begin
      hd  = hd + 4'd1;
      cnt = 5'(RING_DEPTH - 1);
    end
    stamp_ring[user][4'(hd + cnt[3:0])] = now;
    cnt = cnt + 5'd1;
    if (cnt > {1'b0, msg_limit}) begin
      oldest_pos[user] = '0;
      stamp_cnt[user]  = '0;
      return 1'b1;
    end
    oldest_pos[user] = hd;
    stamp_cnt[user]  = cnt;
    return 1'b0;
  endfunction

  // called in the step of a rising edge; leaves tvalid high after the handshake
  task automatic send_word(input logic [5:0] user, input logic [31:0] now, input logic exempt);
    int   gap;
    logic pred;
    gap = $urandom_range(0, sender_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, now, user};
    s_axis_tuser  <= exempt;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = rate_predict(user, now, exempt);
    spam_expect_q.insert(spam_expect_q.size(), pred);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (spam_expect_q.size() != 0);
  endtask

  task automatic write_config(input logic [rlim_pkg::MAXM_W-1:0] limit,
                              input logic [31:0] window);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= rlim_pkg::CFG_MSG_LIMIT;
    cfg_data_i  <= {28'd0, limit};
    @(posedge clk_i);
    cfg_index_i <= rlim_pkg::CFG_WINDOW_MS;
    cfg_data_i  <= window;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    msg_limit  = limit;
    window_len = window;
  endtask

  task automatic test_reset_defaults();
    for (int i = 0; i < 11; i++) begin
      send_word(6'd63, 32'hFFFF_FF00 + 32'(i * 100), 1'b0);
      if (i == 5) send_word(6'd63, 32'd0, 1'b1);
    end
  endtask

  task automatic test_window_expiry();
    write_config(4'd2, 32'd100);
    send_word(6'd0, 32'd0, 1'b0);
    send_word(6'd0, 32'd100, 1'b0);
    send_word(6'd0, 32'd201, 1'b0);
    send_word(6'd0, 32'd250, 1'b0);
    send_word(6'd0, 32'd260, 1'b0);
  endtask

  task automatic test_zero_window();
    write_config(4'd1, 32'd0);
    send_word(6'd17, 32'hFFFF_FFFF, 1'b0);
    send_word(6'd17, 32'hFFFF_FFFF, 1'b0);
    send_word(6'd17, 32'd0, 1'b0);
    send_word(6'd17, 32'd0, 1'b0);
  endtask

  task automatic test_zero_limit();
    write_config(4'd0, 32'd6000);
    send_word(6'd33, $urandom, 1'b0);
    send_word(6'd33, $urandom, 1'b1);
  endtask

  task automatic test_lowered_limit();
    write_config(4'd15, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) send_word(6'd42, $urandom, 1'b0);
    write_config(4'd2, 32'hFFFF_FFFF);
    send_word(6'd42, $urandom, 1'b0);
  endtask

  task automatic test_output_stall();
    write_config(4'd3, 32'd500);
    sender_gap_max = 0;
    hold_request   = 200;
    for (int i = 0; i < 12; i++) begin
      clock_ms = clock_ms + $urandom_range(0, 60);
      send_word(6'(20 + i % 2), clock_ms, 1'(i == 7));
    end
    drain_results();
    sender_gap_max = 4;
  endtask

  task automatic run_traffic(input int items, input int user_base, input int user_span,
                             input int step_max);
    int          r;
    logic [5:0]  user;
    logic [31:0] now;
    logic        exempt;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        user   = 6'($urandom);
        now    = $urandom;
        exempt = 1'($urandom);
      end else begin
        user     = 6'(user_base + $urandom_range(0, user_span));
        clock_ms = clock_ms + $urandom_range(0, step_max);
        now      = clock_ms;
        exempt   = (r < 14);
      end
      send_word(user, now, exempt);
    end
  endtask

  task automatic test_random_traffic();
    write_config(4'd10, 32'd6000);
    run_traffic(115, $urandom_range(0, 63), 1, 700);
    write_config(4'd3, 32'd100);
    run_traffic(115, $urandom_range(0, 63), 1, 40);
    write_config(4'd15, 32'hFFFF_FFFF);
    run_traffic(115, $urandom_range(0, 63), 7, 1000000);
    write_config(4'd1, 32'd0);
    run_traffic(100, $urandom_range(0, 63), 0, 1);
    write_config(4'd0, 32'd500);
    run_traffic(80, 0, 63, 100);
    write_config(4'd7, 32'd2000);
    sender_gap_max = 0;
    recv_gap_max   = 0;
    run_traffic(115, $urandom_range(0, 63), 3, 80);
    sender_gap_max = 4;
    recv_gap_max   = 4;
    write_config(4'd12, 32'd30000);
    clock_ms = 32'hFFFF_0000;
    run_traffic(115, $urandom_range(0, 63), 2, 3000);
  endtask

  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      rx_wait = $urandom_range(0, recv_gap_max);
      m_axis_tready <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait--;
      m_axis_tready <= (rx_wait == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (spam_expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual spamming=%0b",
                 $time, m_axis_tdata[0]);
        mismatch_count++;
      end else begin
        spam_exp = spam_expect_q[0];
        spam_expect_q.delete(0);
        if (m_axis_tdata[0] !== spam_exp) begin
          $display("%0t: spamming mismatch, expected %0b, actual %0b",
                   $time, spam_exp, m_axis_tdata[0]);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    m_axis_tready <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= rlim_pkg::CFG_MSG_LIMIT;
    cfg_data_i    <= '0;
    mismatch_count = 0;
    idle_cycles    = 0;
    rx_wait        = 0;
    hold_left      = 0;
    hold_request   = 0;
    sender_gap_max = 4;
    recv_gap_max   = 4;
    clock_ms       = $urandom;
    msg_limit      = rlim_pkg::MSG_LIMIT_RESET;
    window_len     = rlim_pkg::WINDOW_MS_RESET;
    for (int u = 0; u < N_USERS; u++) begin
      oldest_pos[u] = '0;
      stamp_cnt[u]  = '0;
      for (int d = 0; d < RING_DEPTH; d++) stamp_ring[u][d] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_window_expiry();
    test_zero_window();
    test_zero_limit();
    test_lowered_limit();
    test_output_stall();
    test_random_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && spam_expect_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
